// File: src/limit_order_book_bbo_macros.svh
// assertion macros for the limit order book best bid/offer block
// used by src/limit_order_book_bbo.sv, expects clk and arst_n in scope
`ifndef LIMIT_ORDER_BOOK_BBO_MACROS_SVH
`define LIMIT_ORDER_BOOK_BBO_MACROS_SVH
`ifndef SYNTHESIS
`define LOB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lob assertion failed");
`define LOB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lob assertion failed");
`else
`define LOB_ASSERT_IMP(lbl, ante, cons)
`define LOB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: src/lob_pkg.sv
// shared types and constants for the limit order book best bid/offer block
// no dependencies
`default_nettype none
package lob_pkg;
	localparam int ORDER_SLOTS = 1024;
	localparam int ORDER_AW    = $clog2(ORDER_SLOTS);
	localparam int LEVEL_SLOTS = 64;
	localparam int LEVEL_AW    = $clog2(LEVEL_SLOTS);
	localparam int COUNT_W     = 11;
	localparam int IN_DW       = 136;
	localparam int OUT_DW      = 144;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_MODIFY = 2'd1,
		OP_DELETE = 2'd2,
		OP_TRADE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_APPLIED    = 2'd0,
		STAT_IGNORED    = 2'd1,
		STAT_ORDER_FULL = 2'd2,
		STAT_LEVEL_FULL = 2'd3
	} status_t;

	localparam logic SIDE_BID = 1'b0;
	localparam logic SIDE_ASK = 1'b1;

	typedef struct packed {
		logic        vld;
		logic [63:0] id;
		logic        side;
		logic [31:0] price;
		logic [31:0] qty;
	} ord_ent_t;

	typedef struct packed {
		logic [31:0] price;
		logic [31:0] qty;
	} lvl_ent_t;
endpackage
`default_nettype wire

// File: src/lob_ram.sv
// generic single write port memory with registered read
// no dependencies
`default_nettype none
module lob_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: src/limit_order_book_bbo.sv
// limit order book by order id with best bid/offer report, top level
// depends on lob_pkg, lob_ram and limit_order_book_bbo_macros.svh
//
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tuser op, s_tdata id/side/price/quantity
// m        out  m_tvalid/m_tready  m_tuser status, m_tdata bbo/moved/count
//
// after reset a clearing pass empties the order memory
// an add with an invalid side runs the best-level sweep only
// other messages run an order memory sweep, then, as needed, level sweeps for
// remove, insert and best level
// s_tready is high only in idle; a waiting result does not block new beats,
// but the next result holds in ST_OUT until the waiting one is taken
`default_nettype none
`include "limit_order_book_bbo_macros.svh"
module limit_order_book_bbo import lob_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// oid[63:0] side_code[65:64] price[97:66] quantity[129:98]
	input  logic [IN_DW-1:0]  s_tdata,
	// op[1:0]
	input  logic [1:0]        s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// bid_valid[0] bid_price[32:1] bid_quantity[64:33] ask_valid[65] ask_price[97:66]
	// ask_quantity[129:98] moved[130] live_count[141:131]
	output logic [OUT_DW-1:0] m_tdata,
	// status[1:0]
	output logic [1:0]        m_tuser
);
	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_OSCAN, ST_DECIDE, ST_SUB, ST_SUBWR,
		ST_PUT, ST_PUTWR, ST_OWR1, ST_OWR2, ST_BEST, ST_OUT
	} state_t;

	localparam int OCW = ORDER_AW + 1;
	localparam int LCW = LEVEL_AW + 1;

	state_t                state_q;
	logic [OCW-1:0]        ocnt_q;
	logic [LCW-1:0]        lcnt_q;
	op_t                   op_q;
	logic [63:0]           id_q;
	logic [1:0]            side_q;
	logic [31:0]           price_q;
	logic [31:0]           qty_q;
	status_t               status_q;
	logic [COUNT_W-1:0]    count_q;

	logic                  hit_q;
	logic [ORDER_AW-1:0]   hit_idx_q;
	logic                  hit_side_q;
	logic [31:0]           hit_price_q;
	logic [31:0]           hit_qty_q;
	logic                  free_q;
	logic [ORDER_AW-1:0]   free_idx_q;

	logic [LEVEL_SLOTS-1:0] lvld_q [2];
	logic                  sub_side_q;
	logic [31:0]           sub_price_q;
	logic [31:0]           sub_amt_q;
	logic                  found_q;
	logic [LEVEL_AW-1:0]   found_idx_q;
	logic [31:0]           found_qty_q;
	logic                  lfree_q;
	logic [LEVEL_AW-1:0]   lfree_idx_q;
	logic                  sub_done_q;
	logic [LEVEL_AW-1:0]   sub_idx_q;
	logic [31:0]           sub_oldq_q;

	logic                  bok_q [2];
	logic [31:0]           bp_q  [2];
	logic [31:0]           bq_q  [2];
	logic [129:0]          prev_q;
	logic                  m_tvalid_q;
	logic [OUT_DW-1:0]     m_tdata_q;
	logic [1:0]            m_tuser_q;

	ord_ent_t              ord_rd, ord_wd;
	logic                  ord_we;
	logic [ORDER_AW-1:0]   ord_wa;
	lvl_ent_t              bid_rd, ask_rd, lvl_rd, lvl_wd;
	logic [1:0]            lvl_we;
	logic [LEVEL_AW-1:0]   lvl_wa;
	logic [ORDER_AW-1:0]   oidx;
	logic [LEVEL_AW-1:0]   lidx;
	logic                  put_side, scan_side, lvl_v;
	logic [32:0]           sum;
	logic [31:0]           new_tq;
	logic [129:0]          cur;

	assign oidx      = ORDER_AW'(ocnt_q - 1'b1);
	assign lidx      = LEVEL_AW'(lcnt_q - 1'b1);
	assign put_side  = (op_q == OP_ADD) ? side_q[0] : hit_side_q;
	assign scan_side = (state_q == ST_SUB) ? sub_side_q : put_side;
	assign lvl_rd    = scan_side ? ask_rd : bid_rd;
	assign lvl_v     = lvld_q[scan_side][lidx];
	assign sum       = {1'b0, found_qty_q} + {1'b0, qty_q};
	assign new_tq    = hit_qty_q - sub_amt_q;
	assign cur       = {bq_q[1], bp_q[1], bok_q[1], bq_q[0], bp_q[0], bok_q[0]};

	lob_ram #(.DEPTH(ORDER_SLOTS), .WIDTH($bits(ord_ent_t))) u_ord (
		.clk, .we(ord_we), .waddr(ord_wa), .wdata(ord_wd),
		.raddr(ocnt_q[ORDER_AW-1:0]), .rdata(ord_rd)
	);
	lob_ram #(.DEPTH(LEVEL_SLOTS), .WIDTH($bits(lvl_ent_t))) u_bid (
		.clk, .we(lvl_we[SIDE_BID]), .waddr(lvl_wa), .wdata(lvl_wd),
		.raddr(lcnt_q[LEVEL_AW-1:0]), .rdata(bid_rd)
	);
	lob_ram #(.DEPTH(LEVEL_SLOTS), .WIDTH($bits(lvl_ent_t))) u_ask (
		.clk, .we(lvl_we[SIDE_ASK]), .waddr(lvl_wa), .wdata(lvl_wd),
		.raddr(lcnt_q[LEVEL_AW-1:0]), .rdata(ask_rd)
	);

	// memory write control
	always_comb begin
		ord_we = 1'b0;
		ord_wa = hit_idx_q;
		ord_wd = '0;
		lvl_we = 2'b00;
		lvl_wa = found_idx_q;
		lvl_wd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ord_we = 1'b1;
				ord_wa = ocnt_q[ORDER_AW-1:0];
			end
			ST_OWR1: begin
				ord_we = 1'b1;
			end
			ST_OWR2: begin
				ord_we = 1'b1;
				unique case (op_q)
					OP_ADD: begin
						ord_wa = free_idx_q;
						ord_wd = '{1'b1, id_q, side_q[0], price_q, qty_q};
					end
					OP_MODIFY: begin
						if (qty_q != '0) begin
							ord_wd = '{1'b1, id_q, hit_side_q, price_q, qty_q};
						end
					end
					OP_DELETE: begin
						ord_wd = '0;
					end
					OP_TRADE: begin
						if (new_tq != '0) begin
							ord_wd = '{1'b1, id_q, hit_side_q, hit_price_q, new_tq};
						end
					end
				endcase
			end
			ST_SUBWR: begin
				if (found_q && found_qty_q > sub_amt_q) begin
					lvl_we[sub_side_q] = 1'b1;
					lvl_wd = '{sub_price_q, found_qty_q - sub_amt_q};
				end
			end
			ST_PUTWR: begin
				if (found_q) begin
					lvl_we[put_side] = 1'b1;
					lvl_wd = '{price_q, sum[32] ? 32'hFFFF_FFFF : sum[31:0]};
				end else if (lfree_q) begin
					lvl_we[put_side] = 1'b1;
					lvl_wa = lfree_idx_q;
					lvl_wd = '{price_q, qty_q};
				end else if (sub_done_q) begin
					lvl_we[sub_side_q] = 1'b1;
					lvl_wa = sub_idx_q;
					lvl_wd = '{sub_price_q, sub_oldq_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ocnt_q      <= '0;
			lcnt_q      <= '0;
			op_q        <= OP_ADD;
			id_q        <= '0;
			side_q      <= '0;
			price_q     <= '0;
			qty_q       <= '0;
			status_q    <= STAT_APPLIED;
			count_q     <= '0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			hit_side_q  <= 1'b0;
			hit_price_q <= '0;
			hit_qty_q   <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
			lvld_q[0]   <= '0;
			lvld_q[1]   <= '0;
			sub_side_q  <= 1'b0;
			sub_price_q <= '0;
			sub_amt_q   <= '0;
			found_q     <= 1'b0;
			found_idx_q <= '0;
			found_qty_q <= '0;
			lfree_q     <= 1'b0;
			lfree_idx_q <= '0;
			sub_done_q  <= 1'b0;
			sub_idx_q   <= '0;
			sub_oldq_q  <= '0;
			bok_q[0]    <= 1'b0;
			bok_q[1]    <= 1'b0;
			bp_q[0]     <= '0;
			bp_q[1]     <= '0;
			bq_q[0]     <= '0;
			bq_q[1]     <= '0;
			prev_q      <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			m_tuser_q   <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (ocnt_q == OCW'(ORDER_SLOTS - 1)) begin
						ocnt_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						ocnt_q <= ocnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q       <= op_t'(s_tuser);
						id_q       <= s_tdata[63:0];
						side_q     <= s_tdata[65:64];
						price_q    <= s_tdata[97:66];
						qty_q      <= s_tdata[129:98];
						sub_done_q <= 1'b0;
						ocnt_q     <= '0;
						lcnt_q     <= '0;
						if (op_t'(s_tuser) == OP_ADD && s_tdata[65]) begin
							status_q <= STAT_IGNORED;
							state_q  <= ST_BEST;
						end else begin
							status_q <= STAT_APPLIED;
							state_q  <= ST_OSCAN;
						end
					end
				end
				ST_OSCAN: begin
					if (ocnt_q == '0) begin
						hit_q  <= 1'b0;
						free_q <= 1'b0;
					end else begin
						if (ord_rd.vld && ord_rd.id == id_q && !hit_q) begin
							hit_q       <= 1'b1;
							hit_idx_q   <= oidx;
							hit_side_q  <= ord_rd.side;
							hit_price_q <= ord_rd.price;
							hit_qty_q   <= ord_rd.qty;
						end
						if ((!ord_rd.vld || ord_rd.id == id_q) && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= oidx;
						end
					end
					if (ocnt_q == OCW'(ORDER_SLOTS)) begin
						state_q <= ST_DECIDE;
					end else begin
						ocnt_q <= ocnt_q + 1'b1;
					end
				end
				ST_DECIDE: begin
					lcnt_q      <= '0;
					sub_side_q  <= hit_side_q;
					sub_price_q <= hit_price_q;
					sub_amt_q   <= (op_q == OP_TRADE && qty_q < hit_qty_q) ? qty_q : hit_qty_q;
					if (op_q != OP_ADD && !hit_q) begin
						status_q <= STAT_IGNORED;
						state_q  <= ST_BEST;
					end else if (op_q == OP_ADD && !free_q) begin
						status_q <= STAT_ORDER_FULL;
						state_q  <= ST_BEST;
					end else if (op_q == OP_ADD && !hit_q) begin
						state_q <= ST_PUT;
					end else begin
						state_q <= ST_SUB;
					end
				end
				ST_SUB, ST_PUT: begin
					if (lcnt_q == '0) begin
						found_q <= 1'b0;
						lfree_q <= 1'b0;
					end else begin
						if (lvl_v && lvl_rd.price ==
								((state_q == ST_SUB) ? sub_price_q : price_q) && !found_q) begin
							found_q     <= 1'b1;
							found_idx_q <= lidx;
							found_qty_q <= lvl_rd.qty;
						end
						if (!lvl_v && !lfree_q) begin
							lfree_q     <= 1'b1;
							lfree_idx_q <= lidx;
						end
					end
					if (lcnt_q == LCW'(LEVEL_SLOTS)) begin
						state_q <= (state_q == ST_SUB) ? ST_SUBWR : ST_PUTWR;
					end else begin
						lcnt_q <= lcnt_q + 1'b1;
					end
				end
				ST_SUBWR: begin
					lcnt_q <= '0;
					if (found_q) begin
						sub_done_q <= 1'b1;
						sub_idx_q  <= found_idx_q;
						sub_oldq_q <= found_qty_q;
						if (found_qty_q <= sub_amt_q) begin
							lvld_q[sub_side_q][found_idx_q] <= 1'b0;
						end
					end
					if (op_q == OP_ADD || (op_q == OP_MODIFY && qty_q != '0)) begin
						state_q <= ST_PUT;
					end else begin
						state_q <= ST_OWR2;
					end
				end
				ST_PUTWR: begin
					lcnt_q <= '0;
					if (found_q || lfree_q) begin
						if (!found_q) begin
							lvld_q[put_side][lfree_idx_q] <= 1'b1;
						end
						if (op_q == OP_ADD && hit_q && hit_idx_q != free_idx_q) begin
							state_q <= ST_OWR1;
						end else begin
							state_q <= ST_OWR2;
						end
					end else begin
						status_q <= STAT_LEVEL_FULL;
						if (sub_done_q) begin
							lvld_q[sub_side_q][sub_idx_q] <= 1'b1;
						end
						state_q <= ST_BEST;
					end
				end
				ST_OWR1: begin
					state_q <= ST_OWR2;
				end
				ST_OWR2: begin
					lcnt_q  <= '0;
					state_q <= ST_BEST;
					unique case (op_q)
						OP_ADD: begin
							count_q <= count_q + 1'b1 - COUNT_W'(hit_q);
						end
						OP_MODIFY: begin
							if (qty_q == '0) begin
								count_q <= count_q - 1'b1;
							end
						end
						OP_DELETE: begin
							count_q <= count_q - 1'b1;
						end
						OP_TRADE: begin
							if (new_tq == '0) begin
								count_q <= count_q - 1'b1;
							end
						end
					endcase
				end
				ST_BEST: begin
					if (lcnt_q == '0) begin
						bok_q[0] <= 1'b0;
						bok_q[1] <= 1'b0;
						bp_q[0]  <= '0;
						bp_q[1]  <= '0;
						bq_q[0]  <= '0;
						bq_q[1]  <= '0;
					end else begin
						if (lvld_q[SIDE_BID][lidx] && (!bok_q[0] || bid_rd.price > bp_q[0])) begin
							bok_q[0] <= 1'b1;
							bp_q[0]  <= bid_rd.price;
							bq_q[0]  <= bid_rd.qty;
						end
						if (lvld_q[SIDE_ASK][lidx] && (!bok_q[1] || ask_rd.price < bp_q[1])) begin
							bok_q[1] <= 1'b1;
							bp_q[1]  <= ask_rd.price;
							bq_q[1]  <= ask_rd.qty;
						end
					end
					if (lcnt_q == LCW'(LEVEL_SLOTS)) begin
						state_q <= ST_OUT;
					end else begin
						lcnt_q <= lcnt_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {2'b00, count_q, cur != prev_q, cur};
						m_tuser_q  <= status_q;
						prev_q     <= cur;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`LOB_ASSERT_IMP(a_count_range, 1'b1, count_q <= COUNT_W'(ORDER_SLOTS))
	`LOB_ASSERT_NXT(a_accept_start, s_tvalid && s_tready, state_q == ST_OSCAN || state_q == ST_BEST)
	`LOB_ASSERT_IMP(a_level_full_op, state_q == ST_OUT && status_q == STAT_LEVEL_FULL, op_q == OP_ADD || op_q == OP_MODIFY)
	`LOB_ASSERT_IMP(a_result_from_out, $rose(m_tvalid_q), $past(state_q) == ST_OUT)
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// self-checking testbench for limit_order_book_bbo: drives market messages, predicts
// best bid/offer, live count and status in its own book model and checks every beat
// depends on lob_pkg and the limit_order_book_bbo top level
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lob_pkg::*;

	localparam int RUN_LIMIT = 10_000_000;
	localparam int RAND_MSGS = 420;
	localparam int HOLD_CYCLES = 6000;
	localparam int DRAIN_CYCLES = 2000;

	typedef struct packed {
		bit        bid_ok;
		bit [31:0] bid_px;
		bit [31:0] bid_qt;
		bit        ask_ok;
		bit [31:0] ask_px;
		bit [31:0] ask_qt;
		bit        changed;
		bit [10:0] count;
		bit [1:0]  status;
	} quote_t;

	typedef struct {
		op_t       op;
		bit [63:0] id;
		bit [1:0]  side;
		bit [31:0] px;
		bit [31:0] qt;
		bit        typed;
		quote_t    want;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [IN_DW-1:0]   s_tdata;
	logic [1:0]         s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	logic [OUT_DW-1:0]  m_tdata;
	logic [1:0]         m_tuser;

	ord_ent_t  ords[ORDER_SLOTS];
	ord_ent_t  ords_h[ORDER_SLOTS];
	bit        lv_ok[2][LEVEL_SLOTS];
	bit        lv_ok_h[2][LEVEL_SLOTS];
	lvl_ent_t  lvs[2][LEVEL_SLOTS];
	lvl_ent_t  lvs_h[2][LEVEL_SLOTS];
	int        live_n;
	int        live_n_h;

	quote_t    quotes_due[$];
	dir_row_t  dir_rows[$];
	int        errors;
	bit        idle_on;
	bit        hold_req;
	int        hold_left;
	int        stall_left;

	limit_order_book_bbo i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int find_order(bit [63:0] id);
		for (int i = 0; i < ORDER_SLOTS; i++)
			if (ords[i].vld && ords[i].id == id) return i;
		return -1;
	endfunction

	function automatic int find_level(bit s, bit [31:0] px);
		for (int i = 0; i < LEVEL_SLOTS; i++)
			if (lv_ok[s][i] && lvs[s][i].price == px) return i;
		return -1;
	endfunction

	function automatic void sub_level(bit s, bit [31:0] px, bit [31:0] qt);
		int i;
		i = find_level(s, px);
		if (i < 0) return;
		if (lvs[s][i].qty <= qt) lv_ok[s][i] = 1'b0;
		else lvs[s][i].qty = lvs[s][i].qty - qt;
	endfunction

	function automatic bit put_level(bit s, bit [31:0] px, bit [31:0] qt);
		int i;
		bit [32:0] sum;
		i = find_level(s, px);
		if (i < 0) begin
			for (i = 0; i < LEVEL_SLOTS; i++)
				if (!lv_ok[s][i]) break;
			if (i >= LEVEL_SLOTS) return 1'b0;
			lv_ok[s][i] = 1'b1;
			lvs[s][i].price = px;
			lvs[s][i].qty = '0;
		end
		sum = {1'b0, lvs[s][i].qty} + {1'b0, qt};
		lvs[s][i].qty = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		return 1'b1;
	endfunction

	function automatic void drop_order(int i);
		sub_level(ords[i].side, ords[i].price, ords[i].qty);
		ords[i].vld = 1'b0;
		live_n--;
	endfunction

	function automatic quote_t best_quote();
		quote_t q;
		q = '{default: 0};
		for (int i = 0; i < LEVEL_SLOTS; i++) begin
			if (lv_ok[SIDE_BID][i] && (!q.bid_ok || lvs[SIDE_BID][i].price > q.bid_px)) begin
				q.bid_ok = 1'b1;
				q.bid_px = lvs[SIDE_BID][i].price;
				q.bid_qt = lvs[SIDE_BID][i].qty;
			end
			if (lv_ok[SIDE_ASK][i] && (!q.ask_ok || lvs[SIDE_ASK][i].price < q.ask_px)) begin
				q.ask_ok = 1'b1;
				q.ask_px = lvs[SIDE_ASK][i].price;
				q.ask_qt = lvs[SIDE_ASK][i].qty;
			end
		end
		return q;
	endfunction

	function automatic void keep_book(bit restore);
		for (int i = 0; i < ORDER_SLOTS; i++)
			if (restore) ords[i] = ords_h[i];
			else ords_h[i] = ords[i];
		for (int s = 0; s < 2; s++)
			for (int i = 0; i < LEVEL_SLOTS; i++) begin
				if (restore) begin
					lv_ok[s][i] = lv_ok_h[s][i];
					lvs[s][i] = lvs_h[s][i];
				end else begin
					lv_ok_h[s][i] = lv_ok[s][i];
					lvs_h[s][i] = lvs[s][i];
				end
			end
		if (restore) live_n = live_n_h;
		else live_n_h = live_n;
	endfunction

	function automatic quote_t apply_msg(op_t op, bit [63:0] id, bit [1:0] side,
			bit [31:0] px, bit [31:0] qt);
		quote_t pre;
		quote_t post;
		int i;
		bit [1:0] st;
		bit [31:0] fill;
		pre = best_quote();
		keep_book(1'b0);
		st = STAT_APPLIED;
		if (op == OP_ADD) begin
			if (side > 2'd1) begin
				st = STAT_IGNORED;
			end else begin
				i = find_order(id);
				if (i >= 0) drop_order(i);
				for (i = 0; i < ORDER_SLOTS; i++)
					if (!ords[i].vld) break;
				if (i >= ORDER_SLOTS) begin
					st = STAT_ORDER_FULL;
				end else if (!put_level(side[0], px, qt)) begin
					st = STAT_LEVEL_FULL;
				end else begin
					ords[i] = '{1'b1, id, side[0], px, qt};
					live_n++;
				end
			end
		end else begin
			i = find_order(id);
			if (i < 0) begin
				st = STAT_IGNORED;
			end else if (op == OP_MODIFY) begin
				sub_level(ords[i].side, ords[i].price, ords[i].qty);
				ords[i].price = px;
				ords[i].qty = qt;
				if (qt == 0) begin
					ords[i].vld = 1'b0;
					live_n--;
				end else if (!put_level(ords[i].side, px, qt)) begin
					st = STAT_LEVEL_FULL;
				end
			end else if (op == OP_DELETE) begin
				drop_order(i);
			end else begin
				fill = ords[i].qty < qt ? ords[i].qty : qt;
				sub_level(ords[i].side, ords[i].price, fill);
				ords[i].qty = ords[i].qty - fill;
				if (ords[i].qty == 0) begin
					ords[i].vld = 1'b0;
					live_n--;
				end
			end
		end
		if (st == STAT_ORDER_FULL || st == STAT_LEVEL_FULL) keep_book(1'b1);
		post = best_quote();
		post.changed = pre.bid_ok != post.bid_ok || pre.bid_px != post.bid_px
			|| pre.bid_qt != post.bid_qt || pre.ask_ok != post.ask_ok
			|| pre.ask_px != post.ask_px || pre.ask_qt != post.ask_qt;
		post.count = live_n[10:0];
		post.status = st;
		return post;
	endfunction

	task automatic send_msg(input op_t op, input bit [63:0] id, input bit [1:0] side,
			input bit [31:0] px, input bit [31:0] qt, input bit typed,
			input quote_t want, output quote_t pred);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'b0, qt, px, side, id};
		do @(posedge clk); while (!s_tready);
		pred = apply_msg(op, id, side, px, qt);
		quotes_due.push_back(typed ? want : pred);
	endtask

	// result side: check each beat, random stalls, one long hold-off
	initial begin
		quote_t got;
		quote_t want;
		m_tready <= 1'b0;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.bid_ok  = m_tdata[0];
				got.bid_px  = m_tdata[32:1];
				got.bid_qt  = m_tdata[64:33];
				got.ask_ok  = m_tdata[65];
				got.ask_px  = m_tdata[97:66];
				got.ask_qt  = m_tdata[129:98];
				got.changed = m_tdata[130];
				got.count   = m_tdata[141:131];
				got.status  = m_tuser;
				if (quotes_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat %p", $time, got);
				end else begin
					want = quotes_due.pop_front();
					if (got != want) begin
						errors++;
						$display("%0t: mismatch expected %p actual %p", $time, want, got);
					end
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 13);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin
		quote_t q_idle;
		quote_t pred;
		dir_row_t r;
		op_t op;
		bit [63:0] id;
		bit [1:0] side;
		bit [31:0] px;
		bit [31:0] qt;
		int k;

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= '0;
		s_tdata <= '0;
		errors = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		live_n = 0;
		foreach (ords[i]) ords[i] = '0;
		foreach (lv_ok[s, i]) begin
			lv_ok[s][i] = 1'b0;
			lvs[s][i] = '0;
		end
		q_idle = '{default: 0};
		q_idle.status = STAT_IGNORED;

		dir_rows.push_back('{OP_DELETE, 64'd5, 2'd0, 32'd0, 32'd0, 1'b1, q_idle});
		dir_rows.push_back('{OP_ADD, 64'd9, 2'd2, 32'd50, 32'd5, 1'b1, q_idle});
		dir_rows.push_back('{OP_ADD, '1, 2'd3, '1, '1, 1'b1, q_idle});
		dir_rows.push_back('{OP_ADD, 64'd1, 2'd0, 32'd100, 32'd10, 1'b1,
			'{1'b1, 32'd100, 32'd10, 1'b0, 32'd0, 32'd0, 1'b1, 11'd1, STAT_APPLIED}});
		dir_rows.push_back('{OP_ADD, '1, 2'd1, '1, '1, 1'b0, q_idle});
		dir_rows.push_back('{OP_ADD, 64'd3, 2'd1, '1, 32'd5, 1'b0, q_idle});
		dir_rows.push_back('{OP_ADD, 64'd4, 2'd0, 32'd0, 32'd0, 1'b0, q_idle});
		dir_rows.push_back('{OP_ADD, 64'd1, 2'd0, 32'd200, 32'd7, 1'b0, q_idle});
		dir_rows.push_back('{OP_MODIFY, 64'd1, 2'd0, 32'd150, 32'd3, 1'b0, q_idle});
		dir_rows.push_back('{OP_MODIFY, 64'd1, 2'd0, 32'd150, 32'd0, 1'b0, q_idle});
		dir_rows.push_back('{OP_TRADE, '1, 2'd0, 32'd0, 32'd1, 1'b0, q_idle});
		dir_rows.push_back('{OP_TRADE, 64'd3, 2'd0, 32'd0, '1, 1'b0, q_idle});
		dir_rows.push_back('{OP_TRADE, 64'd77, 2'd0, 32'd0, 32'd1, 1'b0, q_idle});
		dir_rows.push_back('{OP_MODIFY, 64'd78, 2'd0, 32'd5, 32'd5, 1'b0, q_idle});
		dir_rows.push_back('{OP_DELETE, '1, 2'd0, 32'd0, 32'd0, 1'b0, q_idle});
		dir_rows.push_back('{OP_DELETE, 64'd4, 2'd0, 32'd0, 32'd0, 1'b0, q_idle});
		dir_rows.push_back('{OP_DELETE, 64'd4, 2'd0, 32'd0, 32'd0, 1'b0, q_idle});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[n]) begin
			r = dir_rows[n];
			send_msg(r.op, r.id, r.side, r.px, r.qt, r.typed, r.want, pred);
		end

		// random traffic over a small id pool so most messages hit live orders
		for (int n = 0; n < RAND_MSGS; n++) begin
			if (n == 100) hold_req = 1'b1;
			k = $urandom_range(0, 99);
			op = k < 40 ? OP_ADD : k < 60 ? OP_MODIFY : k < 75 ? OP_DELETE : OP_TRADE;
			id = $urandom_range(0, 9) == 0 ? {$urandom, $urandom}
				: {32'h8000_0000 * $urandom_range(0, 1), 32'($urandom_range(0, 23))};
			side = $urandom_range(0, 19) == 0 ? 2'($urandom_range(2, 3))
				: 2'($urandom_range(0, 1));
			px = $urandom_range(0, 15) == 0 ? $urandom : 32'd1000 + $urandom_range(0, 24);
			k = $urandom_range(0, 19);
			qt = k == 0 ? 32'd0 : k < 3 ? $urandom : 32'($urandom_range(1, 50));
			send_msg(op, id, side, px, qt, 1'b0, q_idle, pred);
		end

		// fill the bid level table until an add is refused, then clear those orders
		idle_on = 1'b0;
		k = 0;
		do begin
			send_msg(OP_ADD, 64'h1_0000_0000 + k, 2'd0, 32'd2_000_000 + k, 32'd1,
				1'b0, q_idle, pred);
			k++;
		end while (pred.status != STAT_LEVEL_FULL && k < 200);
		for (int n = 0; n < k; n++)
			send_msg(OP_DELETE, 64'h1_0000_0000 + n, 2'd0, 32'd0, 32'd0, 1'b0, q_idle, pred);
		s_tvalid <= 1'b0;

		while (quotes_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
